### hdl/ouks_pkg.sv
// ----------------------------------------------------------------------------
// Ordered unique key set: shared types and codes
// Command and status codes, fixed port widths and the control word that the
// top level drives into each storage cell.
// ----------------------------------------------------------------------------
package ouks_pkg;

    localparam int CMD_BITS    = 2;
    localparam int KEY_IN_BITS = 16;
    localparam int STATUS_BITS = 2;
    localparam int FIELD_BITS  = 5;

    localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FIND   = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_DONE        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DUPLICATE   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOT_PRESENT = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_FULL        = 2'd3;

    typedef struct packed {
        logic probe;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

### hdl/ordered_unique_key_set.sv
// ----------------------------------------------------------------------------
// Ordered unique key set
// A bounded set of unique keys in insertion order, held in a row of cells.
//
//   Channel   Ports                                     Transaction
//   command   start, busy, command, key                 start high, busy low
//   result    done, status, position, steps, entry_count done high, one cycle
//
// For each command, in the accepting cycle every cell compares its key with
// the probe, and in the next cycle the match is encoded and the row is
// updated (append, or shift down to close a gap). The result appears on the
// cycle after that, while a new command may already be accepted.
// Reset clears all valid bits and the entry count at once; the receiver
// cannot stall.
// ----------------------------------------------------------------------------
module ordered_unique_key_set #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [ouks_pkg::CMD_BITS-1:0]         command,
    input  logic [ouks_pkg::KEY_IN_BITS-1:0]      key,
    output logic                                  done,
    output logic [ouks_pkg::STATUS_BITS-1:0]      status,
    output logic [ouks_pkg::FIELD_BITS-1:0]       position,
    output logic [ouks_pkg::FIELD_BITS-1:0]       steps,
    output logic [ouks_pkg::FIELD_BITS-1:0]       entry_count
);
    import ouks_pkg::*;

    localparam int KW = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_ACT  = 1'b1;

    logic                   phase_reg;
    logic                   phase_next;
    logic [CMD_BITS-1:0]    cmd_reg;
    logic [KW-1:0]          key_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   done_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [STATUS_BITS-1:0] status_next;
    logic [CW-1:0]          pos_reg;
    logic [CW-1:0]          pos_next;
    logic [CW-1:0]          steps_reg;
    logic [CW-1:0]          steps_next;

    logic                   accept;
    logic [KW-1:0]          probe_key;
    logic [KW-1:0]          cell_key   [CAPACITY];
    logic                   cell_valid [CAPACITY];
    logic [CAPACITY-1:0]    match;
    logic                   hit;
    logic [IW-1:0]          idx;
    logic [CW-1:0]          hit_pos;
    logic                   do_append;
    logic                   do_remove;
    cell_ctrl_t             ctrl [CAPACITY];

    assign accept    = start && (phase_reg == PH_IDLE);
    assign busy      = (phase_reg == PH_ACT);
    assign probe_key = key[KW-1:0];

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match[i])
            begin
                idx = idx | IW'(i);
            end
        end
    end

    assign hit     = |match;
    assign hit_pos = CW'(idx) + CW'(1);

    always_comb
    begin
        status_next = ST_NOT_PRESENT;
        pos_next    = '0;
        steps_next  = '0;
        count_next  = count_reg;
        do_append   = 1'b0;
        do_remove   = 1'b0;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                if (hit)
                begin
                    status_next = ST_DUPLICATE;
                    pos_next    = hit_pos;
                    steps_next  = hit_pos;
                end
                else if (count_reg == CW'(CAPACITY))
                begin
                    status_next = ST_FULL;
                    steps_next  = count_reg;
                end
                else
                begin
                    status_next = ST_DONE;
                    pos_next    = count_reg + CW'(1);
                    steps_next  = count_reg;
                    count_next  = count_reg + CW'(1);
                    do_append   = 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (hit)
                begin
                    status_next = ST_DONE;
                    pos_next    = hit_pos;
                    steps_next  = hit_pos;
                    count_next  = count_reg - CW'(1);
                    do_remove   = 1'b1;
                end
                else
                begin
                    steps_next = count_reg;
                end
            end
            CMD_FIND:
            begin
                if (hit)
                begin
                    status_next = ST_DONE;
                    pos_next    = hit_pos;
                    steps_next  = hit_pos;
                end
                else
                begin
                    steps_next = count_reg;
                end
            end
            default:
            begin
                status_next = ST_NOT_PRESENT;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [KW-1:0] upper_key;
            logic          upper_valid;

            if (g == CAPACITY - 1)
            begin : g_last
                assign upper_key   = '0;
                assign upper_valid = 1'b0;
            end
            else
            begin : g_mid
                assign upper_key   = cell_key[g+1];
                assign upper_valid = cell_valid[g+1];
            end

            assign ctrl[g].probe = accept;
            assign ctrl[g].load  = (phase_reg == PH_ACT) && do_append
                                   && (count_reg == CW'(g));
            assign ctrl[g].shift = (phase_reg == PH_ACT) && do_remove
                                   && (IW'(g) >= idx);

            ouks_cell #(
                .KW(KW)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl[g]),
                .probe_key  (probe_key),
                .load_key   (key_reg),
                .next_key   (upper_key),
                .next_valid (upper_valid),
                .key_q      (cell_key[g]),
                .valid_q    (cell_valid[g]),
                .match_q    (match[g])
            );
        end
    endgenerate

    always_comb
    begin
        unique case (phase_reg)
            PH_IDLE: phase_next = accept ? PH_ACT : PH_IDLE;
            PH_ACT:  phase_next = PH_IDLE;
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            key_reg <= probe_key;
        end
        if (phase_reg == PH_ACT)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            steps_reg  <= steps_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == PH_ACT);
            if (phase_reg == PH_ACT)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = FIELD_BITS'(pos_reg);
    assign steps       = FIELD_BITS'(steps_reg);
    assign entry_count = FIELD_BITS'(count_reg);

endmodule

### hdl/ouks_cell.sv
// ----------------------------------------------------------------------------
// Ordered unique key set: storage cell
// Holds one key and its valid bit, compares a probe key, loads a new key and
// can take the key of its upper neighbour when the row closes a gap.
// ----------------------------------------------------------------------------
module ouks_cell #(
    parameter int KW = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ouks_pkg::cell_ctrl_t ctrl,
    input  logic [KW-1:0]       probe_key,
    input  logic [KW-1:0]       load_key,
    input  logic [KW-1:0]       next_key,
    input  logic                next_valid,
    output logic [KW-1:0]       key_q,
    output logic                valid_q,
    output logic                match_q
);
    import ouks_pkg::*;

    logic [KW-1:0] key_reg;
    logic [KW-1:0] key_next;
    logic          valid_reg;
    logic          valid_next;
    logic          match_reg;
    logic          match_next;

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctrl.probe)
        begin
            match_next = valid_reg && (key_reg == probe_key);
        end
        if (ctrl.load)
        begin
            key_next   = load_key;
            valid_next = 1'b1;
        end
        else if (ctrl.shift)
        begin
            key_next   = next_key;
            valid_next = next_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    assign key_q   = key_reg;
    assign valid_q = valid_reg;
    assign match_q = match_reg;

endmodule

### tb/key_set_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered unique key set: result checker
// Watches the command and result channels, keeps its own copy of the key
// table to predict each reply, and compares every reply field by field with
// the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module key_set_checker #(
    parameter int SET_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic [ouks_pkg::CMD_BITS-1:0]    command,
    input  logic [ouks_pkg::KEY_IN_BITS-1:0] key,
    input  logic                             done,
    input  logic [ouks_pkg::STATUS_BITS-1:0] status,
    input  logic [ouks_pkg::FIELD_BITS-1:0]  position,
    input  logic [ouks_pkg::FIELD_BITS-1:0]  steps,
    input  logic [ouks_pkg::FIELD_BITS-1:0]  entry_count,
    output int                               errors,
    output int                               outstanding
);
    import ouks_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [FIELD_BITS-1:0]  position;
        logic [FIELD_BITS-1:0]  steps;
        logic [FIELD_BITS-1:0]  count;
    } set_reply_t;

    logic [KEY_IN_BITS-1:0] held_keys [SET_DEPTH];
    int                     held_n;
    int                     mismatch_n;
    set_reply_t             awaited_results [$];

    function automatic set_reply_t apply_command(input logic [CMD_BITS-1:0] c,
                                                 input logic [KEY_IN_BITS-1:0] k);
        set_reply_t r;
        int         prior;
        int         idx;
        r = '{status: ST_NOT_PRESENT, position: '0, steps: '0, count: '0};
        prior = held_n;
        if (c == CMD_ADD || c == CMD_REMOVE || c == CMD_FIND)
        begin
            idx = prior;
            for (int i = 0; i < prior; i++)
            begin
                if (idx == prior && held_keys[i] == k)
                    idx = i;
            end
            if (idx < prior)
            begin
                r.position = FIELD_BITS'(idx + 1);
                r.steps    = FIELD_BITS'(idx + 1);
                if (c == CMD_ADD)
                    r.status = ST_DUPLICATE;
                else
                begin
                    r.status = ST_DONE;
                    if (c == CMD_REMOVE)
                    begin
                        for (int i = idx; i + 1 < prior; i++)
                            held_keys[i] = held_keys[i + 1];
                        held_n = prior - 1;
                    end
                end
            end
            else
            begin
                r.steps = FIELD_BITS'(prior);
                if (c != CMD_ADD)
                    r.status = ST_NOT_PRESENT;
                else if (prior >= SET_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    held_keys[prior] = k;
                    held_n           = prior + 1;
                    r.position       = FIELD_BITS'(prior + 1);
                    r.status         = ST_DONE;
                end
            end
        end
        r.count = FIELD_BITS'(held_n);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input set_reply_t want,
                                 input set_reply_t seen);
        mismatch_n++;
        if (mismatch_n <= 10)
            $display("%0t: %s: expected status %0d position %0d steps %0d count %0d, ",
                     $realtime, what, want.status, want.position, want.steps, want.count,
                     "got status %0d position %0d steps %0d count %0d",
                     seen.status, seen.position, seen.steps, seen.count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        set_reply_t seen;
        set_reply_t want;
        if (!rst_n)
        begin
            held_n = 0;
            mismatch_n = 0;
            awaited_results.delete();
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                seen = '{status: status, position: position, steps: steps,
                         count: entry_count};
                if (awaited_results.size() == 0)
                    note_mismatch("result with no transaction waiting", '0, seen);
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.status != seen.status || want.position != seen.position ||
                        want.steps != seen.steps || want.count != seen.count)
                        note_mismatch("result mismatch", want, seen);
                end
            end
            if (start && !busy)
                awaited_results.push_back(apply_command(command, key));
            errors <= mismatch_n;
            outstanding <= awaited_results.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered unique key set: testbench top
// Drives add, remove, find and undefined commands into the key set, first a
// directed walk through duplicates, a full table and gap closing, then random
// phases over a small key pool so that the table fills and empties repeatedly.
// ----------------------------------------------------------------------------
module tb;
    import ouks_pkg::*;

    localparam int SET_DEPTH  = 16;
    localparam int IDLE_LIMIT = 500;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [CMD_BITS-1:0]    command;
    logic [KEY_IN_BITS-1:0] key;
    logic                   done;
    logic [STATUS_BITS-1:0] status;
    logic [FIELD_BITS-1:0]  position;
    logic [FIELD_BITS-1:0]  steps;
    logic [FIELD_BITS-1:0]  entry_count;
    int                     errors;
    int                     outstanding;
    int                     idle_cycles;
    bit                     quiet;

    ordered_unique_key_set #(
        .CAPACITY(SET_DEPTH),
        .KEY_BITS(KEY_IN_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .key(key),
        .done(done),
        .status(status),
        .position(position),
        .steps(steps),
        .entry_count(entry_count)
    );

    key_set_checker #(
        .SET_DEPTH(SET_DEPTH)
    ) checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .key(key),
        .done(done),
        .status(status),
        .position(position),
        .steps(steps),
        .entry_count(entry_count),
        .errors(errors),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic issue(input logic [CMD_BITS-1:0] c, input logic [KEY_IN_BITS-1:0] k);
        if (!quiet && $urandom_range(0, 99) < 36)
        begin
            start <= 1'b0;
            command <= CMD_BITS'($urandom);
            key <= KEY_IN_BITS'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        command <= c;
        key <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int                     add_pct [6] = '{70, 55, 40, 65, 30, 50};
        logic [KEY_IN_BITS-1:0] pool_base;
        logic [KEY_IN_BITS-1:0] k;
        logic [CMD_BITS-1:0]    c;
        int                     r;
        rst_n = 1'b0;
        quiet = 1'b0;
        start <= 1'b0;
        command <= CMD_ADD;
        key <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(CMD_ADD, 16'hFFFF);
        issue(CMD_ADD, 16'h0000);
        issue(CMD_ADD, 16'h0000);
        issue(CMD_FIND, 16'hFFFF);
        issue(CMD_FIND, 16'h1234);
        issue(CMD_BITS'(3), 16'h0000);
        issue(CMD_REMOVE, 16'hFFFF);
        issue(CMD_REMOVE, 16'hFFFF);
        issue(CMD_FIND, 16'h0000);
        for (int i = 1; i < SET_DEPTH; i++)
            issue(CMD_ADD, KEY_IN_BITS'(16'h1000 + i));
        issue(CMD_ADD, 16'hABCD);
        issue(CMD_ADD, 16'h0000);
        issue(CMD_REMOVE, 16'h1007);
        issue(CMD_REMOVE, 16'h100F);
        issue(CMD_FIND, 16'h1008);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            quiet = (phase == 2);
            pool_base = KEY_IN_BITS'($urandom);
            for (int n = 0; n < 125; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    c = CMD_BITS'(3);
                else if (r < add_pct[phase])
                    c = CMD_ADD;
                else if (r < add_pct[phase] + (100 - add_pct[phase]) / 2)
                    c = CMD_REMOVE;
                else
                    c = CMD_FIND;
                if ($urandom_range(0, 99) < 85)
                    k = pool_base + KEY_IN_BITS'($urandom_range(0, 23));
                else
                    k = KEY_IN_BITS'($urandom);
                issue(c, k);
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### ordered_unique_key_set.f
hdl/ouks_pkg.sv
hdl/ouks_cell.sv
hdl/ordered_unique_key_set.sv
tb/key_set_checker.sv
tb/tb.sv
